### sv/spwm_pkg.sv
package spwm_pkg;

    typedef longint unsigned u64_t;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_BITS        = 16;

    localparam int LOG2_DEPTH  = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER     = SINE_TABLE_DEPTH / 4;
    localparam int ROM_ENTRIES = QUARTER + 1;
    localparam int ROM_ADDR_W  = LOG2_DEPTH - 1;
    localparam int AMP_W       = SINE_BITS - 1;
    localparam longint AMPLITUDE = (longint'(1) <<< AMP_W) - 1;

    localparam int ANGLE_W = 32;
    localparam int CFG_W   = 32;
    localparam int CMP_W   = 16;
    localparam int DEPTH_W = 16;

    localparam int MUL_BITS = 16;
    localparam int CNT_W    = $clog2(MUL_BITS);
    localparam int MCAND_W  = (AMP_W > 16) ? AMP_W : 16;
    localparam int PROD_W   = MCAND_W + MUL_BITS;

    localparam logic [ANGLE_W-1:0] THIRD_TURN   = 32'h5555_5555;
    localparam logic [DEPTH_W-1:0] DEPTH_ONE    = 16'h8000;
    localparam logic [CMP_W-1:0]   PERIOD_RESET = 16'd27500;
    localparam logic [CMP_W:0]     HALF_DUTY    = 17'h0_8000;
    localparam u64_t               HALF_PI_Q30  = 64'd1686629713;

    typedef enum logic [1:0] {
        REG_PHASE_STEP     = 2'd0,
        REG_MOD_DEPTH      = 2'd1,
        REG_CARRIER_PERIOD = 2'd2,
        REG_RUN_ENABLE     = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_M1GO,
        S_M1,
        S_M2GO,
        S_M2,
        S_DONE
    } spwm_state_t;

    typedef enum logic [1:0] {
        PH_U,
        PH_V,
        PH_W
    } phase_t;

    typedef logic [AMP_W-1:0] sine_mag_t;
    typedef sine_mag_t sine_rom_t [ROM_ENTRIES];

    typedef struct packed {
        logic      neg;
        sine_mag_t mag;
    } sine_samp_t;

    typedef struct packed {
        logic                start;
        logic [MCAND_W-1:0]  mcand;
        logic [MUL_BITS-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

    // sin(theta) in Q30 for theta in Q30 radians, 0..pi/2, Taylor series to x^15
    function automatic longint sine_q30(input u64_t theta);
        longint sum;
        u64_t   mag;
        sum = longint'(theta);
        mag = theta;
        for (int n = 1; n <= 7; n++)
        begin
            mag = (mag * theta) >> 30;
            mag = (mag * theta) >> 30;
            case (n)
                1:       mag = mag / 64'd6;
                2:       mag = mag / 64'd20;
                3:       mag = mag / 64'd42;
                4:       mag = mag / 64'd72;
                5:       mag = mag / 64'd110;
                6:       mag = mag / 64'd156;
                default: mag = mag / 64'd210;
            endcase
            if ((n % 2) == 1)
                sum = sum - longint'(mag);
            else
                sum = sum + longint'(mag);
        end
        if (sum < 0)
            sum = 0;
        return sum;
    endfunction

    // quarter wave, entry i covers table index i of the first quadrant
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        u64_t      theta;
        longint    v;
        for (int i = 0; i < ROM_ENTRIES; i++)
        begin
            theta = (u64_t'(4 * i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            v = (sine_q30(theta) * AMPLITUDE + (longint'(1) <<< 29)) >>> 30;
            if (v > AMPLITUDE)
                v = AMPLITUDE;
            rom[i] = sine_mag_t'(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### sv/spwm_tick_if.sv
interface spwm_tick_if;
    logic valid;
    logic ready;
    logic update_tick;

    modport source (output valid, output update_tick, input ready);
    modport sink (input valid, input update_tick, output ready);
endinterface

### sv/spwm_cmp_if.sv
interface spwm_cmp_if;
    logic        valid;
    logic        ready;
    logic [15:0] compare_u;
    logic [15:0] compare_v;
    logic [15:0] compare_w;

    modport source (output valid, output compare_u, output compare_v, output compare_w,
                    input ready);
    modport sink (input valid, input compare_u, input compare_v, input compare_w,
                  output ready);
endinterface

### sv/spwm_sine_rom.sv
module spwm_sine_rom (
    input  logic                           clk,
    input  logic [spwm_pkg::ANGLE_W-1:0]   angle,
    output spwm_pkg::sine_samp_t           samp
);
    import spwm_pkg::*;

    logic [LOG2_DEPTH-1:0] idx;
    logic [1:0]            quadrant;
    logic [LOG2_DEPTH-3:0] frac;
    logic [ROM_ADDR_W-1:0] addr;
    sine_samp_t            samp_reg;
    sine_samp_t            samp_next;

    // fold onto the first quadrant; the second and fourth run backward
    always_comb
    begin
        idx      = angle[ANGLE_W-1 -: LOG2_DEPTH];
        quadrant = idx[LOG2_DEPTH-1 -: 2];
        frac     = idx[LOG2_DEPTH-3:0];
        if (quadrant[0])
            addr = ROM_ADDR_W'(QUARTER) - ROM_ADDR_W'(frac);
        else
            addr = ROM_ADDR_W'(frac);
        samp_next.neg = quadrant[1];
        samp_next.mag = SINE_ROM[addr];
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
    end

    assign samp = samp_reg;
endmodule

### sv/spwm_sermul.sv
module spwm_sermul (
    input  logic                clk,
    input  logic                rst_n,
    input  spwm_pkg::mul_req_t  req,
    output spwm_pkg::mul_rsp_t  rsp
);
    import spwm_pkg::*;

    logic [MCAND_W-1:0]  mcand_reg;
    logic [MCAND_W-1:0]  hi_reg;
    logic [MCAND_W-1:0]  hi_next;
    logic [MUL_BITS-1:0] lo_reg;
    logic [MUL_BITS-1:0] lo_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [MCAND_W:0]    sum;
    logic                last;

    // one multiplier bit a cycle, LSB first, shift the partial product right
    always_comb
    begin
        sum     = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        hi_next = sum[MCAND_W:1];
        lo_next = {sum[0], lo_reg[MUL_BITS-1:1]};
        last    = (cnt_reg == CNT_W'(MUL_BITS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            busy_reg <= !last;
            done_reg <= last;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg <= req.mcand;
            hi_reg    <= '0;
            lo_reg    <= req.mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = {hi_reg, lo_reg};

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    a_done_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && $past(cnt_reg) == CNT_W'(MUL_BITS - 1)))
        else $error("done without a final iteration");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last && !req.start) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after its last bit");
endmodule

### sv/three_phase_sine_pwm_generator_unit.sv
// Three-phase sine PWM compare generator. Each accepted request whose update_tick
// bit is set, while run_enable is 1, yields one result: compare_u, compare_v and
// compare_w for the current electrical angle, with V lagging and W leading U by a
// third of a turn; the angle then advances by phase_step (32-bit, wraps). A request
// with update_tick clear, or any request while disabled, is dropped: no result,
// angle unchanged. Each sample comes from a quarter-wave sine table, is scaled by
// modulation_depth (Q1.15, above 1.0 used as 1.0), centered at half duty and
// scaled to carrier_period, so every compare lies within 0..carrier_period.
// Writing run_enable = 1 clears the angle. Registers: 0 phase_step, 1
// modulation_depth, 2 carrier_period, 3 run_enable; write them only while idle.
// Sequencing: one shared bit-serial 16-bit multiplier does all the arithmetic,
// two products per phase and three phases in turn, and a request is not taken
// while an earlier one is still in work. The next request is taken once the
// result before it has moved to the output register. A dropped request leaves
// the block idle and ready for the next one. The result sits in an output
// register, so a new request can start while the last result still waits to be
// taken.
module three_phase_sine_pwm_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  spwm_pkg::reg_index_t          cfg_index,
    input  logic [spwm_pkg::CFG_W-1:0]    cfg_wdata,
    spwm_tick_if.sink                     tick,
    spwm_cmp_if.source                    cmp
);
    import spwm_pkg::*;

    // configuration and angle state
    logic [ANGLE_W-1:0] step_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [CMP_W-1:0]   period_reg;
    logic               run_en_reg;
    logic [ANGLE_W-1:0] acc_reg;
    logic [ANGLE_W-1:0] acc_next;

    // sequencer
    spwm_state_t        state_reg;
    spwm_state_t        state_next;
    phase_t             ph_reg;
    phase_t             ph_next;
    logic [ANGLE_W-1:0] angle_reg;
    logic [ANGLE_W-1:0] angle_sel;

    // per-phase results and the output register
    logic [CMP_W-1:0]   res_u_reg;
    logic [CMP_W-1:0]   res_v_reg;
    logic [CMP_W-1:0]   res_w_reg;
    logic [CMP_W-1:0]   out_u_reg;
    logic [CMP_W-1:0]   out_v_reg;
    logic [CMP_W-1:0]   out_w_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic               accept;
    logic               start_item;
    logic               capture;
    logic               load_out;

    sine_samp_t         samp;
    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;

    logic [CMP_W-1:0]   floor_part;
    logic               rem_nz;
    logic [CMP_W:0]     duty_word;
    logic [CMP_W-1:0]   duty;
    logic [CMP_W-1:0]   compare_val;
    logic [DEPTH_W-1:0] depth_clamped;

    spwm_sine_rom u_rom (
        .clk   (clk),
        .angle (angle_sel),
        .samp  (samp)
    );

    spwm_sermul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign accept     = tick.valid && tick.ready;
    assign start_item = accept && tick.update_tick && run_en_reg;
    assign tick.ready = (state_reg == S_IDLE);

    // angle of the phase in work
    always_comb
    begin
        case (ph_reg)
            PH_V:    angle_sel = angle_reg - THIRD_TURN;
            PH_W:    angle_sel = angle_reg + THIRD_TURN;
            default: angle_sel = angle_reg;
        endcase
    end

    // first product m*|s|; floor for positive samples, ceiling for negative ones,
    // so the offset below is floor(m*s / 2^(SINE_BITS-1)) and centers at half duty
    always_comb
    begin
        floor_part = mul_rsp.product[AMP_W +: CMP_W];
        rem_nz     = |mul_rsp.product[AMP_W-1:0];
        if (samp.neg)
            duty_word = HALF_DUTY - ({1'b0, floor_part} + {{CMP_W{1'b0}}, rem_nz});
        else
            duty_word = HALF_DUTY + {1'b0, floor_part};
        duty        = duty_word[CMP_W-1:0];
        compare_val = mul_rsp.product[CMP_W +: CMP_W];
    end

    always_comb
    begin
        mul_req.start  = 1'b0;
        mul_req.mcand  = MCAND_W'(samp.mag);
        mul_req.mplier = depth_reg;
        state_next     = state_reg;
        ph_next        = ph_reg;
        capture        = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start_item)
                begin
                    state_next = S_LOOK;
                    ph_next    = PH_U;
                end
            end
            S_LOOK:
            begin
                state_next = S_M1GO;
            end
            S_M1GO:
            begin
                mul_req.start = 1'b1;
                state_next    = S_M1;
            end
            S_M1:
            begin
                if (mul_rsp.done)
                    state_next = S_M2GO;
            end
            S_M2GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = MCAND_W'(period_reg);
                mul_req.mplier = duty;
                state_next     = S_M2;
            end
            S_M2:
            begin
                if (mul_rsp.done)
                begin
                    capture = 1'b1;
                    case (ph_reg)
                        PH_U:
                        begin
                            ph_next    = PH_V;
                            state_next = S_LOOK;
                        end
                        PH_V:
                        begin
                            ph_next    = PH_W;
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || cmp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_U;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    // configuration writes; clamp the depth at write time
    always_comb
    begin
        depth_clamped = (cfg_wdata[DEPTH_W-1:0] > DEPTH_ONE) ? DEPTH_ONE
                                                              : cfg_wdata[DEPTH_W-1:0];
        acc_next = acc_reg;
        if (start_item)
            acc_next = acc_reg + step_reg;
        if (cfg_wr_en && cfg_index == REG_RUN_ENABLE && cfg_wdata[0])
            acc_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            depth_reg  <= '0;
            period_reg <= PERIOD_RESET;
            run_en_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PHASE_STEP:     step_reg   <= cfg_wdata[ANGLE_W-1:0];
                    REG_MOD_DEPTH:      depth_reg  <= depth_clamped;
                    REG_CARRIER_PERIOD: period_reg <= cfg_wdata[CMP_W-1:0];
                    REG_RUN_ENABLE:     run_en_reg <= cfg_wdata[0];
                    default:            ;
                endcase
            end
        end
    end

    // snapshot the angle for this request; results per phase
    always_ff @(posedge clk)
    begin
        if (start_item)
            angle_reg <= acc_reg;
        if (capture)
        begin
            case (ph_reg)
                PH_U:    res_u_reg <= compare_val;
                PH_V:    res_v_reg <= compare_val;
                default: res_w_reg <= compare_val;
            endcase
        end
        if (load_out)
        begin
            out_u_reg <= res_u_reg;
            out_v_reg <= res_v_reg;
            out_w_reg <= res_w_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmp.ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign cmp.valid     = out_valid_reg;
    assign cmp.compare_u = out_u_reg;
    assign cmp.compare_v = out_v_reg;
    assign cmp.compare_w = out_w_reg;

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start_item |=> (state_reg == S_LOOK && ph_reg == PH_U))
        else $error("enabled tick did not start a computation");

    a_idle_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        tick.ready |-> !mul_rsp.busy)
        else $error("request taken while the multiplier is still busy");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || cmp.ready))
        |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result not moved to the output register");
endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    // Predictor constants, kept local to the bench.
    localparam int          WAVE_DEPTH       = 1024;
    localparam int          WAVE_ADDR_W      = $clog2(WAVE_DEPTH);
    localparam int          WAVE_FRAC        = 15;
    localparam longint      WAVE_PEAK        = (longint'(1) <<< WAVE_FRAC) - 1;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic [31:0] ONE_THIRD_TURN   = 32'h5555_5555;
    localparam logic [15:0] FULL_DEPTH       = 16'h8000;
    localparam logic [15:0] START_PERIOD     = 16'd27500;

    // Bench timing.
    localparam int          DRAIN_CYCLES     = 250;
    localparam int          HOLD_CYCLES      = 1000;
    localparam int          RANDOM_TICKS     = 950;
    localparam int          MAX_REPORTS      = 30;
    localparam longint      RUN_LIMIT_NS     = 64'd40_000_000;

    typedef struct packed {
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] w;
    } compare_set_t;

    // Tracks the register mirror and electrical angle, predicts the three compare
    // values per enabled tick and checks the results in order.
    class compare_tracker;
        logic [31:0]  step;
        logic [31:0]  angle;
        logic [15:0]  depth;
        logic [15:0]  period;
        logic         running;
        longint       wave [WAVE_DEPTH];
        compare_set_t pending [$];
        int unsigned  errors;

        function new();
            for (int k = 0; k < WAVE_DEPTH; k++)
                wave[k] = wave_sample(k);
            step    = '0;
            angle   = '0;
            depth   = '0;
            period  = START_PERIOD;
            running = 1'b0;
            errors  = 0;
        endfunction

        // Q30 sine of a Q30 angle within the first quadrant, odd terms up to x^15.
        function longint taylor_q30(longint unsigned theta);
            longint          acc;
            longint unsigned term;
            acc  = longint'(theta);
            term = theta;
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * theta) >> 30;
                term = (term * theta) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            return acc;
        endfunction

        // Fold the index into the first quadrant, evaluate, restore the sign.
        function longint wave_sample(int k);
            longint unsigned pos;
            longint unsigned folded;
            longint unsigned theta;
            longint          level;
            logic            negative;
            pos      = 4 * k;
            negative = pos > 2 * WAVE_DEPTH;
            if (pos <= WAVE_DEPTH)
                folded = pos;
            else if (pos <= 2 * WAVE_DEPTH)
                folded = 2 * WAVE_DEPTH - pos;
            else if (pos <= 3 * WAVE_DEPTH)
                folded = pos - 2 * WAVE_DEPTH;
            else
                folded = 4 * WAVE_DEPTH - pos;
            theta = (folded * QUARTER_TURN_Q30) / WAVE_DEPTH;
            level = (taylor_q30(theta) * WAVE_PEAK + (longint'(1) <<< 29)) >>> 30;
            if (level > WAVE_PEAK)
                level = WAVE_PEAK;
            return negative ? -level : level;
        endfunction

        // Scale by depth (floor), center at half duty, scale to the period, clamp.
        function logic [15:0] phase_compare(logic [31:0] ang, longint m);
            longint s;
            longint t;
            longint c;
            s = wave[ang[31 -: WAVE_ADDR_W]];
            t = (m * s) >>> WAVE_FRAC;
            c = longint'(period) * (32768 + t);
            if (c < 0)
                c = 0;
            c = c >>> 16;
            if (c > longint'(period))
                c = longint'(period);
            return c[15:0];
        endfunction

        function void mirror_write(spwm_pkg::reg_index_t idx, logic [31:0] data);
            case (idx)
                spwm_pkg::REG_PHASE_STEP:     step   = data;
                spwm_pkg::REG_MOD_DEPTH:      depth  = data[15:0];
                spwm_pkg::REG_CARRIER_PERIOD: period = data[15:0];
                spwm_pkg::REG_RUN_ENABLE:
                begin
                    running = data[0];
                    if (running)
                        angle = '0;
                end
                default: ;
            endcase
        endfunction

        // Note an accepted request; return 1 when it is due to produce a result.
        function bit note_tick(logic tick_bit);
            compare_set_t want;
            longint       m;
            if (!tick_bit || !running)
                return 1'b0;
            m = (depth > FULL_DEPTH) ? longint'(FULL_DEPTH) : longint'(depth);
            want.u = phase_compare(angle, m);
            want.v = phase_compare(angle - ONE_THIRD_TURN, m);
            want.w = phase_compare(angle + ONE_THIRD_TURN, m);
            pending.push_back(want);
            angle = angle + step;
            return 1'b1;
        endfunction

        function void flag(string field, logic [15:0] want, logic [15:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_compares(logic [15:0] u, logic [15:0] v, logic [15:0] w);
            compare_set_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result u=%0d v=%0d w=%0d, expected none",
                             $time, u, v, w);
                return;
            end
            want = pending.pop_front();
            if (u !== want.u)
                flag("compare_u", want.u, u);
            if (v !== want.v)
                flag("compare_v", want.v, v);
            if (w !== want.w)
                flag("compare_w", want.w, w);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    spwm_pkg::reg_index_t cfg_index;
    logic [31:0]          cfg_wdata;

    spwm_tick_if tick_ch ();
    spwm_cmp_if  cmp_ch ();

    compare_tracker tracker;

    // Per-phase idling switches and the one-shot request for a long receiver hold-off.
    bit tx_idles;
    bit rx_idles;
    bit hold_results;

    three_phase_sine_pwm_generator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tick      (tick_ch),
        .cmp       (cmp_ch)
    );

    always #10 clk = ~clk;

    // Hard stop: far beyond the slowest correct run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // If tx_idles, wait a random gap; then hold one request until the block takes it.
    // Drive at the falling edge; sample the handshake at the rising edge.
    task automatic send_request(input logic tick_bit, output bit caused);
        int gap;
        gap = tx_idles ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.update_tick <= tick_bit;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        caused = tracker.note_tick(tick_bit);
    endtask

    // Drop the request line, then wait for every pending result plus the latency
    // margin, so that a dropped request still in flight has left the block too.
    task automatic settle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register write: enable sampled at the rising edge, mirror updated after it.
    task automatic write_reg(input spwm_pkg::reg_index_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        tracker.mirror_write(idx, data);
    endtask

    // Settle the block, write the selected registers back to back, drop the enable.
    task automatic configure(input bit [3:0] which, input logic [31:0] step_word,
                             input logic [31:0] depth_word, input logic [31:0] period_word,
                             input logic [31:0] enable_word);
        settle();
        if (which[0])
            write_reg(spwm_pkg::REG_PHASE_STEP, step_word);
        if (which[1])
            write_reg(spwm_pkg::REG_MOD_DEPTH, depth_word);
        if (which[2])
            write_reg(spwm_pkg::REG_CARRIER_PERIOD, period_word);
        if (which[3])
            write_reg(spwm_pkg::REG_RUN_ENABLE, enable_word);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: random ready gaps, one long hold-off on request, check on accept.
    initial
    begin : result_sink
        int gap;
        cmp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = rx_idles ? $urandom_range(0, 7) : 0;
            if (hold_results)
            begin
                hold_results = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                cmp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            cmp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!cmp_ch.valid);
            tracker.check_compares(cmp_ch.compare_u, cmp_ch.compare_v, cmp_ch.compare_w);
        end
    end

    initial
    begin : stimulus
        int          produced;
        int          count;
        int          phase_no;
        bit          caused;
        bit [3:0]    which;
        logic        tick_bit;
        logic [31:0] step_word;
        logic [31:0] depth_word;
        logic [31:0] period_word;
        logic [31:0] enable_word;

        tracker = new();

        // Hold every input at a known value from time zero.
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = spwm_pkg::REG_PHASE_STEP;
        cfg_wdata           = '0;
        tick_ch.valid       = 1'b0;
        tick_ch.update_tick = 1'b0;
        tx_idles            = 1'b1;
        rx_idles            = 1'b1;
        hold_results        = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Ticks straight out of reset: block is disabled, nothing comes back.
        send_request(1'b1, caused);
        send_request(1'b0, caused);
        send_request(1'b1, caused);

        // Quarter-turn steps at full depth and full period: hit zero, peak, zero,
        // trough and the wrap back to zero; slip in a request with the tick clear.
        configure(4'hF, 32'h4000_0000, 32'h0000_8000, 32'h0000_FFFF, 32'h0000_0001);
        send_request(1'b1, caused);
        send_request(1'b1, caused);
        send_request(1'b0, caused);
        send_request(1'b1, caused);
        send_request(1'b1, caused);
        send_request(1'b1, caused);

        // Depth above one, zero period, largest step; enable written with junk
        // in the upper bits, which also clears the angle once more.
        configure(4'hF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(1'b1, caused);
        send_request(1'b1, caused);
        send_request(1'b1, caused);

        // Smallest nonzero period and depth, upper data bits set and ignored.
        configure(4'hF, 32'h0000_0001, 32'hFFFF_0001, 32'hFFFF_0001, 32'h0000_0001);
        send_request(1'b1, caused);
        send_request(1'b1, caused);

        // Disable with the upper bits set: ticks are dropped and the angle holds.
        configure(4'hF, 32'h0000_0000, 32'hABCD_4000, 32'h0000_FFFF, 32'hFFFF_FFFE);
        send_request(1'b1, caused);
        send_request(1'b1, caused);

        // Re-enable with a step of one third of a turn, rounded down.
        configure(4'hF, 32'h5555_5555, 32'h0000_7FFF, 32'h0000_6B6C, 32'h0000_0001);
        send_request(1'b1, caused);
        send_request(1'b1, caused);
        send_request(1'b1, caused);

        // Random phases: fresh settings each time, then a burst of requests, mostly
        // real ticks with some cleared ones as noise.
        produced = 0;
        phase_no = 0;
        while (produced < RANDOM_TICKS)
        begin
            case ($urandom_range(0, 5))
                0:       step_word = 32'h0000_0000;
                1:       step_word = 32'hFFFF_FFFF;
                2:       step_word = $urandom_range(1, 32'h00FF_FFFF);
                default: step_word = $urandom();
            endcase
            depth_word = $urandom();
            case ($urandom_range(0, 5))
                0:       depth_word[15:0] = 16'h0000;
                1:       depth_word[15:0] = FULL_DEPTH;
                2:       depth_word[15:0] = 16'hFFFF;
                3:       depth_word[15:0] = 16'($urandom_range(32769, 65535));
                default: depth_word[15:0] = 16'($urandom_range(0, 32768));
            endcase
            period_word = $urandom();
            case ($urandom_range(0, 5))
                0:       period_word[15:0] = 16'h0000;
                1:       period_word[15:0] = 16'hFFFF;
                2:       period_word[15:0] = 16'h0001;
                default: ;
            endcase
            enable_word    = $urandom();
            enable_word[0] = ($urandom_range(0, 6) != 0);
            which          = 4'($urandom());
            count          = $urandom_range(10, 50);

            // One phase runs enabled with a steady sender while the receiver
            // holds off, so the block fills and stalls its request side.
            if (phase_no == 1)
            begin
                which[3]       = 1'b1;
                enable_word[0] = 1'b1;
                count          = 40;
            end

            configure(which, step_word, depth_word, period_word, enable_word);

            tx_idles = (phase_no != 1) && ($urandom_range(0, 3) != 0);
            rx_idles = ($urandom_range(0, 3) != 0);
            if (phase_no == 1)
                hold_results = 1'b1;

            repeat (count)
            begin
                tick_bit = ($urandom_range(0, 9) != 0);
                send_request(tick_bit, caused);
                if (caused)
                    produced++;
            end
            phase_no++;
        end

        // Drain: every expectation met, then a latency margin for stray results.
        settle();
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/spwm_pkg.sv
sv/spwm_tick_if.sv
sv/spwm_cmp_if.sv
sv/spwm_sine_rom.sv
sv/spwm_sermul.sv
sv/three_phase_sine_pwm_generator_unit.sv
tb/tb.sv
